// ===== hw/rtl/fall_detect_monitor_macros.svh =====
`ifndef FALL_DETECT_MONITOR_MACROS_SVH
`define FALL_DETECT_MONITOR_MACROS_SVH

// Assumes clk and rst_n are in scope.
`define FDM_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define FDM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fdm_pkg.sv =====
package fdm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int THR_W    = 16;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int EVENT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOV_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_URGENT_TIME = 3'd4;

    localparam logic [THR_W-1:0] ACCEL_THR_RST   = 16'd40000;
    localparam logic [THR_W-1:0] GYRO_THR_RST    = 16'd20000;
    localparam logic [THR_W-1:0] RECOV_THR_RST   = 16'd18000;
    localparam logic [MS_W-1:0]  FALL_TIME_RST   = 24'd2000;
    localparam logic [MS_W-1:0]  URGENT_TIME_RST = 24'd10000;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 3'd0,
        EV_FALL_START = 3'd1,
        EV_URGENT     = 3'd2,
        EV_RECOVERED  = 3'd3,
        EV_MILD_FALL  = 3'd4,
        EV_CLEARED    = 3'd5
    } event_t;

    typedef struct packed {
        logic [THR_W-1:0] accel_thr;
        logic [THR_W-1:0] gyro_thr;
        logic [THR_W-1:0] recov_thr;
        logic [MS_W-1:0]  fall_time;
        logic [MS_W-1:0]  urgent_time;
    } cfg_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic              start_hit;
        logic              recovered;
        logic [TIME_W-1:0] time_ms;
    } item_t;

endpackage

// ===== hw/rtl/fdm_ifs.sv =====
interface fdm_sample_if
    import fdm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] gyro_x;
    logic signed [SAMPLE_BITS-1:0] gyro_y;
    logic signed [SAMPLE_BITS-1:0] gyro_z;
    logic [TIME_W-1:0]             time_ms;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
        output ready
    );
endinterface

interface fdm_result_if
    import fdm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               fall_pending;
    logic               urgent_active;
    logic [EVENT_W-1:0] event_res;

    modport source (
        output valid, fall_pending, urgent_active, event_res,
        input  ready
    );
    modport sink (
        input  valid, fall_pending, urgent_active, event_res,
        output ready
    );
endinterface

// ===== hw/rtl/fdm_front.sv =====
module fdm_front
    import fdm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fdm_sample_if.sink   sample,
    input  cfg_t         cfg,
    output logic         push_valid,
    input  logic         push_ready,
    output item_t        push_item
);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int TSQ_W = 2 * THR_W;
    localparam int CMP_W = (SQ_W > TSQ_W) ? SQ_W : TSQ_W;

    logic [SAMPLE_BITS-1:0] raw [6];
    logic [SAMPLE_BITS-1:0] mag [6];
    logic [SQ_W-1:0]        sq  [6];

    logic [SQ_W-1:0]   s1_sq_reg [6];
    logic [TIME_W-1:0] s1_time_reg;
    logic              s1_valid_reg;
    item_t             s2_item_reg;
    logic              s2_valid_reg;

    logic [TSQ_W-1:0] ta2_reg;
    logic [TSQ_W-1:0] tg2_reg;
    logic [TSQ_W-1:0] tr2_reg;

    logic [SQ_W-1:0] a2;
    logic [SQ_W-1:0] g2;
    item_t           s2_item_next;
    logic            advance;

    assign raw[0] = sample.accel_x;
    assign raw[1] = sample.accel_y;
    assign raw[2] = sample.accel_z;
    assign raw[3] = sample.gyro_x;
    assign raw[4] = sample.gyro_y;
    assign raw[5] = sample.gyro_z;

    // one squarer per axis
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            mag[i] = raw[i][SAMPLE_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
            sq[i]  = SQ_W'(mag[i]) * SQ_W'(mag[i]);
        end
    end

    // squared thresholds, refreshed every cycle
    always_ff @(posedge clk)
    begin
        ta2_reg <= TSQ_W'(cfg.accel_thr) * TSQ_W'(cfg.accel_thr);
        tg2_reg <= TSQ_W'(cfg.gyro_thr) * TSQ_W'(cfg.gyro_thr);
        tr2_reg <= TSQ_W'(cfg.recov_thr) * TSQ_W'(cfg.recov_thr);
    end

    assign a2 = s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
    assign g2 = s1_sq_reg[3] + s1_sq_reg[4] + s1_sq_reg[5];

    always_comb
    begin
        s2_item_next.start_hit = (CMP_W'(a2) >= CMP_W'(ta2_reg)) &&
                                 (CMP_W'(g2) >= CMP_W'(tg2_reg));
        s2_item_next.recovered = CMP_W'(a2) <= CMP_W'(tr2_reg);
        s2_item_next.time_ms   = s1_time_reg;
    end

    assign advance      = !s2_valid_reg || push_ready;
    assign sample.ready = advance;
    assign push_valid   = s2_valid_reg;
    assign push_item    = s2_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= sample.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 6; i++)
            begin
                s1_sq_reg[i] <= sq[i];
            end
            s1_time_reg <= sample.time_ms;
            s2_item_reg <= s2_item_next;
        end
    end

endmodule

// ===== hw/rtl/fdm_queue.sv =====
`include "fall_detect_monitor_macros.svh"

module fdm_queue
    import fdm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `FDM_ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count above depth")
    `FDM_ASSERT_NEXT(a_count_push, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

// ===== hw/rtl/fdm_back.sv =====
`include "fall_detect_monitor_macros.svh"

module fdm_back
    import fdm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  item_t         pop_item,
    fdm_result_if.source  result
);
    logic              fall_reg;
    logic              urgent_reg;
    logic [TIME_W-1:0] start_reg;
    logic              fall_next;
    logic              urgent_next;
    logic [TIME_W-1:0] start_next;
    event_t            event_next;

    logic              out_valid_reg;
    logic              out_fall_reg;
    logic              out_urgent_reg;
    event_t            out_event_reg;

    logic [TIME_W-1:0] elapsed;
    logic              ge_urgent;
    logic              ge_fall;
    logic              pop;

    assign pop_ready = !out_valid_reg || result.ready;
    assign pop       = pop_valid && pop_ready;

    // while urgent, elapsed time counts as past the urgent limit
    assign elapsed   = pop_item.time_ms - start_reg;
    assign ge_urgent = urgent_reg || (elapsed >= TIME_W'(cfg.urgent_time));
    assign ge_fall   = elapsed >= TIME_W'(cfg.fall_time);

    always_comb
    begin
        fall_next   = fall_reg;
        urgent_next = urgent_reg;
        start_next  = start_reg;
        event_next  = EV_NONE;
        priority if (!fall_reg && pop_item.start_hit)
        begin
            fall_next  = 1'b1;
            start_next = pop_item.time_ms;
            event_next = EV_FALL_START;
        end
        else if (fall_reg)
        begin
            if (pop_item.recovered)
            begin
                priority if (ge_urgent)
                begin
                    urgent_next = 1'b0;
                    event_next  = EV_RECOVERED;
                end
                else if (ge_fall)
                begin
                    event_next = EV_MILD_FALL;
                end
                else
                begin
                    event_next = EV_CLEARED;
                end
                fall_next  = 1'b0;
                start_next = '0;
            end
            else if (ge_urgent && !urgent_reg)
            begin
                urgent_next = 1'b1;
                event_next  = EV_URGENT;
            end
        end
        else
        begin
            event_next = EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_reg      <= 1'b0;
            urgent_reg    <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                fall_reg   <= fall_next;
                urgent_reg <= urgent_next;
                start_reg  <= start_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_fall_reg   <= fall_next;
            out_urgent_reg <= urgent_next;
            out_event_reg  <= event_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.fall_pending  = out_fall_reg;
    assign result.urgent_active = out_urgent_reg;
    assign result.event_res     = out_event_reg;

    `FDM_ASSERT_IMPLIES(a_urgent_in_fall, urgent_reg, fall_reg, "urgent without pending fall")
    `FDM_ASSERT_IMPLIES(a_urgent_event, out_valid_reg && (out_event_reg == EV_URGENT),
        out_urgent_reg && out_fall_reg, "urgent event without flags")
    `FDM_ASSERT_NEXT(a_fall_start, pop && !fall_reg && pop_item.start_hit,
        fall_reg && (start_reg == $past(pop_item.time_ms)), "fall start not recorded")

endmodule

// ===== hw/rtl/fall_detect_monitor.sv =====
// Fall detection monitor.
// sample channel (sink): one accelerometer/gyroscope sample per transaction with
//   its millisecond timestamp. result channel (source): one result per sample with
//   fall_pending, urgent_active and event_res (0 none, 1 fall start, 2 urgent,
//   3 recovered from urgent, 4 mild fall, 5 cleared silently).
// Config: cfg_we/cfg_index/cfg_data write thresholds and times; write only while
//   the block has no samples outstanding.
// Throughput: one sample per cycle while the result side keeps up. A sample's result
//   passes the squarer stage, the sum/compare stage, the queue and the output register.
// When the result side stalls, the output register holds and the queue fills;
//   sample.ready drops once the queue is full and the sum/compare stage holds a sample.
// Reset (rst_n, asynchronous): thresholds return to their defaults, no fall is
//   pending, all queued and in-flight samples are dropped.
module fall_detect_monitor
    import fdm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fdm_sample_if.sink           sample,
    fdm_result_if.source         result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    cfg_t  cfg_reg;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_thr   <= ACCEL_THR_RST;
            cfg_reg.gyro_thr    <= GYRO_THR_RST;
            cfg_reg.recov_thr   <= RECOV_THR_RST;
            cfg_reg.fall_time   <= FALL_TIME_RST;
            cfg_reg.urgent_time <= URGENT_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEL_THR:   cfg_reg.accel_thr   <= cfg_data[THR_W-1:0];
                CFG_GYRO_THR:    cfg_reg.gyro_thr    <= cfg_data[THR_W-1:0];
                CFG_RECOV_THR:   cfg_reg.recov_thr   <= cfg_data[THR_W-1:0];
                CFG_FALL_TIME:   cfg_reg.fall_time   <= cfg_data[MS_W-1:0];
                CFG_URGENT_TIME: cfg_reg.urgent_time <= cfg_data[MS_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    fdm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .result    (result)
    );

endmodule
